### rtl/gelu_pkg.sv
// ----------------------------------------------------------------------------
// gelu_pkg
// Shared widths, fixed-point constants, the tanh point table and stage types
// for the GELU (tanh form) pipeline.
// ----------------------------------------------------------------------------
package gelu_pkg;

  localparam int DATA_W  = 16;
  localparam int FRAC_W  = 12;
  localparam int MAG_W   = DATA_W;
  localparam int IQ      = 24;

  localparam int COEF_W     = 16;
  localparam int CUBE_Q     = 20;
  localparam int CUBE_SHIFT = 3 * FRAC_W + CUBE_Q - IQ;
  localparam int SQ_W       = 24;

  localparam logic [COEF_W-1:0] CUBE_COEF  = COEF_W'(46886);
  localparam logic [SQ_W-1:0]   SQRT_COEF  = SQ_W'(13386282);

  localparam int A2_W     = 2 * MAG_W - 1;
  localparam int AC_W     = MAG_W + COEF_W - 1;
  localparam int P_W      = A2_W + AC_W;
  localparam int TERM_W   = P_W - CUBE_SHIFT;
  localparam int INNER_W  = 31;
  localparam int UPROD_W  = INNER_W + SQ_W;
  localparam int U_W      = UPROD_W - IQ;

  localparam logic [P_W-1:0]     CUBE_RND = P_W'(1) << (CUBE_SHIFT - 1);
  localparam logic [UPROD_W-1:0] U_RND    = UPROD_W'(1) << (IQ - 1);

  localparam int TANH_SEGS  = 64;
  localparam int SEG_IDX_W  = $clog2(TANH_SEGS);
  localparam int SEG_FRAC_W = IQ + 2 - SEG_IDX_W;
  localparam int PT_IDX_W   = $clog2(TANH_SEGS + 1);
  localparam int PT_W       = 16;
  localparam int DIFF_W     = 13;
  localparam int IP_W       = DIFF_W + SEG_FRAC_W;
  localparam int T_W        = 17;
  localparam int FACT_W     = T_W + 1;
  localparam int MPROD_W    = MAG_W + FACT_W;
  localparam int OUT_SHIFT  = 17;
  localparam int RES_W      = MPROD_W - OUT_SHIFT;

  localparam logic [IP_W-1:0]    IP_RND   = IP_W'(1) << (SEG_FRAC_W - 1);
  localparam logic [T_W-1:0]     TANH_ONE = T_W'(65536);
  localparam logic [MPROD_W-1:0] OUT_RND  = MPROD_W'(1) << (OUT_SHIFT - 1);
  localparam logic [RES_W-1:0]   POS_MAX  = RES_W'((1 << (DATA_W - 1)) - 1);
  localparam logic [RES_W-1:0]   NEG_MAX  = RES_W'(1 << (DATA_W - 1));

  localparam logic [PT_W-1:0] TANH_PTS [TANH_SEGS+1] = '{
        0,  4091,  8150, 12146, 16051, 19838, 23485, 26973,
    30285, 33412, 36346, 39084, 41625, 43972, 46131, 48108,
    49912, 51552, 53038, 54382, 55593, 56683, 57660, 58536,
    59320, 60019, 60643, 61199, 61694, 62134, 62524, 62871,
    63179, 63451, 63693, 63907, 64096, 64263, 64412, 64543,
    64659, 64761, 64852, 64932, 65003, 65065, 65120, 65169,
    65212, 65250, 65283, 65313, 65339, 65362, 65383, 65401,
    65417, 65431, 65443, 65454, 65464, 65472, 65480, 65486,
    65492
  };

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } gelu_side_t;

  typedef struct packed {
    gelu_side_t            side;
    logic                  sat;
    logic [SEG_IDX_W-1:0]  idx;
    logic [SEG_FRAC_W-1:0] frac;
  } gelu_arg_t;

  typedef struct packed {
    gelu_side_t     side;
    logic [T_W-1:0] t;
  } gelu_tanh_t;

endpackage

### rtl/gelu_arg.sv
// ----------------------------------------------------------------------------
// gelu_arg
// Six-stage front end: magnitude, cube via a^2 * (a*c), rounding and the
// scaled tanh argument, split into segment index and fraction.
// ----------------------------------------------------------------------------
module gelu_arg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [gelu_pkg::DATA_W-1:0] sample,
  output logic                        out_vld,
  output gelu_pkg::gelu_arg_t         arg
);
  import gelu_pkg::*;

  logic [5:0]            vld_r;
  logic [5:0]            vld_nxt;
  gelu_side_t            side_r [5];
  gelu_side_t            side_nxt;
  logic [2*MAG_W-1:0]    sq_full;
  logic [MAG_W+COEF_W-1:0] ac_full;
  logic [A2_W-1:0]       a2_r;
  logic [AC_W-1:0]       ac_r;
  logic [P_W-1:0]        p_r;
  logic [P_W-1:0]        p_nxt;
  logic [P_W-1:0]        term_sum;
  logic [INNER_W-1:0]    inner_r;
  logic [INNER_W-1:0]    inner_nxt;
  logic [UPROD_W-1:0]    uprod_r;
  logic [UPROD_W-1:0]    uprod_nxt;
  logic [UPROD_W-1:0]    u_sum;
  logic [U_W-1:0]        u;
  gelu_arg_t             arg_r;
  gelu_arg_t             arg_nxt;

  assign vld_nxt = {vld_r[4:0], in_vld};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // magnitude and sign
  always_comb begin
    side_nxt.neg = sample[DATA_W-1];
    side_nxt.mag = sample[DATA_W-1] ? MAG_W'(~sample + 1'b1) : MAG_W'(sample);
  end

  assign sq_full   = side_r[0].mag * side_r[0].mag;
  assign ac_full   = side_r[0].mag * CUBE_COEF;
  assign p_nxt     = a2_r * ac_r;
  assign term_sum  = p_r + CUBE_RND;
  assign inner_nxt = INNER_W'({side_r[2].mag, {(IQ - FRAC_W){1'b0}}})
                   + INNER_W'(term_sum[P_W-1:CUBE_SHIFT]);
  assign uprod_nxt = inner_r * SQRT_COEF;
  assign u_sum     = uprod_r + U_RND;
  assign u         = u_sum[UPROD_W-1:IQ];

  always_comb begin
    arg_nxt.side = side_r[4];
    arg_nxt.sat  = |u[U_W-1:IQ+2];
    arg_nxt.idx  = u[IQ+1:SEG_FRAC_W];
    arg_nxt.frac = u[SEG_FRAC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      for (int i = 1; i < 5; i++) begin
        side_r[i] <= side_r[i-1];
      end
      a2_r    <= sq_full[A2_W-1:0];
      ac_r    <= ac_full[AC_W-1:0];
      p_r     <= p_nxt;
      inner_r <= inner_nxt;
      uprod_r <= uprod_nxt;
      arg_r   <= arg_nxt;
    end
  end

  assign out_vld = vld_r[5];
  assign arg     = arg_r;

endmodule

### rtl/gelu_tanh.sv
// ----------------------------------------------------------------------------
// gelu_tanh
// Two-stage tanh: reads the two segment end points from the point table,
// then interpolates linearly with rounding; saturates to one past the table.
// ----------------------------------------------------------------------------
module gelu_tanh (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  gelu_pkg::gelu_arg_t  arg,
  output logic                 out_vld,
  output gelu_pkg::gelu_tanh_t tanh_val
);
  import gelu_pkg::*;

  logic [1:0]            vld_r;
  logic [PT_IDX_W-1:0]   lo_idx;
  logic [PT_IDX_W-1:0]   hi_idx;
  logic [PT_W-1:0]       lo_pt;
  logic [PT_W-1:0]       hi_pt;
  logic [PT_W-1:0]       lo_r;
  logic [DIFF_W-1:0]     diff_nxt;
  logic [DIFF_W-1:0]     diff_r;
  logic [SEG_FRAC_W-1:0] frac_r;
  logic                  sat_r;
  gelu_side_t            side_r;
  logic [IP_W-1:0]       ip_sum;
  gelu_tanh_t            tanh_r;
  gelu_tanh_t            tanh_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[0], in_vld};
    end
  end

  assign lo_idx   = PT_IDX_W'(arg.idx);
  assign hi_idx   = lo_idx + 1'b1;
  assign lo_pt    = TANH_PTS[lo_idx];
  assign hi_pt    = TANH_PTS[hi_idx];
  assign diff_nxt = DIFF_W'(hi_pt - lo_pt);

  assign ip_sum = diff_r * frac_r + IP_RND;

  always_comb begin
    tanh_nxt.side = side_r;
    if (sat_r) begin
      tanh_nxt.t = TANH_ONE;
    end else begin
      tanh_nxt.t = T_W'(lo_r) + T_W'(ip_sum[IP_W-1:SEG_FRAC_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo_r   <= lo_pt;
      diff_r <= diff_nxt;
      frac_r <= arg.frac;
      sat_r  <= arg.sat;
      side_r <= arg.side;
      tanh_r <= tanh_nxt;
    end
  end

  assign out_vld  = vld_r[1];
  assign tanh_val = tanh_r;

endmodule

### rtl/gelu_tanh_approximation_core.sv
// ----------------------------------------------------------------------------
// gelu_tanh_approximation_core
// GELU, tanh form, on signed Q4.12 samples: 0.5*x*(1+tanh(k*(x+c*x^3))).
// ----------------------------------------------------------------------------
// Usage:
//   in_valid / in_sample_in carry one signed Q4.12 sample per item; the
//   block raises in_stall only while out_stall holds a waiting result.
//   out_valid / out_gelu_out return one Q4.12 result per item, rounded to
//   nearest and clamped at the format limits, in input order.
//   Throughput: one item per cycle while out_stall does not hold a waiting
//   result; every stage of the ten-stage pipeline advances on a common
//   enable.
//   When out_stall is high with out_valid, every stage holds, so in_stall
//   rises in the same cycle and no item is lost or repeated.
//   Reset (rst_n low, synchronous) clears all valid bits; the data registers
//   are not reset, and the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module gelu_tanh_approximation_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [gelu_pkg::DATA_W-1:0] in_sample_in,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gelu_pkg::DATA_W-1:0] out_gelu_out
);
  import gelu_pkg::*;

  logic               en;
  logic               arg_vld;
  gelu_arg_t          arg;
  logic               t_vld;
  gelu_tanh_t         tanh_val;
  logic [FACT_W-1:0]  factor;
  logic [MPROD_W-1:0] mprod_nxt;
  logic [MPROD_W-1:0] mprod_r;
  logic               mprod_vld_r;
  logic               mprod_neg_r;
  logic [MPROD_W-1:0] res_sum;
  logic [RES_W-1:0]   res_mag;
  logic [RES_W-1:0]   res_clamp;
  logic [DATA_W-1:0]  out_nxt;
  logic [DATA_W-1:0]  out_gelu_r;
  logic               out_vld_r;
  logic               out_neg_r;

  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  gelu_arg u_arg (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .sample  (in_sample_in),
    .out_vld (arg_vld),
    .arg     (arg)
  );

  gelu_tanh u_tanh (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (arg_vld),
    .arg      (arg),
    .out_vld  (t_vld),
    .tanh_val (tanh_val)
  );

  // 1 - tanh for negative x, 1 + tanh otherwise
  assign factor = tanh_val.side.neg ? (FACT_W'(TANH_ONE) - FACT_W'(tanh_val.t))
                                    : (FACT_W'(TANH_ONE) + FACT_W'(tanh_val.t));
  assign mprod_nxt = tanh_val.side.mag * factor;

  assign res_sum = mprod_r + OUT_RND;
  assign res_mag = res_sum[MPROD_W-1:OUT_SHIFT];

  always_comb begin
    if (mprod_neg_r) begin
      res_clamp = (res_mag > NEG_MAX) ? NEG_MAX : res_mag;
      out_nxt   = DATA_W'(~res_clamp + 1'b1);
    end else begin
      res_clamp = (res_mag > POS_MAX) ? POS_MAX : res_mag;
      out_nxt   = DATA_W'(res_clamp);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mprod_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else if (en) begin
      mprod_vld_r <= t_vld;
      out_vld_r   <= mprod_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mprod_r     <= mprod_nxt;
      mprod_neg_r <= tanh_val.side.neg;
      out_gelu_r  <= out_nxt;
      out_neg_r   <= mprod_neg_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_gelu_out = out_gelu_r;

  a_tanh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    t_vld |-> tanh_val.t <= TANH_ONE)
    else $error("tanh value above one");

  a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_neg_r |-> !out_gelu_r[DATA_W-1])
    else $error("negative result for non-negative item");

  a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_neg_r |-> out_gelu_r[DATA_W-1] || out_gelu_r == '0)
    else $error("positive result for negative item");

endmodule
